### rtl/ple_pkg.sv
// Shared types, widths and codes for the positional list engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ple_pkg;

  // List size and index widths; an index of CAPACITY marks the end of the list.
  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] NIL_INDEX = IDX_W'(CAPACITY);

  // Field widths of the item formats.
  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 16;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 5;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_VAL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BELOW_ONE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OUT_BOUNDS = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd5;

  // Write controls of the node memories.
  typedef struct packed {
    logic              val_we;
    logic [SLOT_W-1:0] val_addr;
    logic [VAL_W-1:0]  val_data;
    logic              link_we;
    logic [SLOT_W-1:0] link_addr;
    logic [IDX_W-1:0]  link_data;
  } node_wr_t;

  // Allocation and release requests for the free map.
  typedef struct packed {
    logic              set_en;
    logic [SLOT_W-1:0] set_slot;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_slot;
  } map_upd_t;

endpackage

`default_nettype wire

### rtl/ple_node_store.sv
// Node memories of the list: one value and one next index per slot.
// Synchronous, registered read; depends on ple_pkg.
`default_nettype none

module ple_node_store
  import ple_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output logic      [VAL_W-1:0]  rd_value,
  output logic      [IDX_W-1:0]  rd_link,
  input  wire node_wr_t          wr
);

  logic [VAL_W-1:0] node_values [CAPACITY];
  logic [IDX_W-1:0] node_links  [CAPACITY];

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      node_values[wr.val_addr] <= wr.val_data;
    end
    rd_value <= node_values[rd_addr];
  end

  // Link memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      node_links[wr.link_addr] <= wr.link_data;
    end
    rd_link <= node_links[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/ple_free_map.sv
// Occupancy map of the node slots, with the lowest free slot kept in a register.
// Depends on ple_pkg.
`default_nettype none

module ple_free_map
  import ple_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire map_upd_t          upd,
  output logic      [SLOT_W-1:0] free_slot,
  output logic                   map_full
);

  logic [CAPACITY-1:0] used_map;
  logic [SLOT_W-1:0]   lowest;

  // Priority search for the lowest clear bit.
  always_comb begin
    lowest = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_map[i]) begin
        lowest = SLOT_W'(i);
      end
    end
  end

  assign map_full = &used_map;

  // Map updates; the free slot is registered, so it follows the map in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map  <= '0;
      free_slot <= '0;
    end else begin
      if (upd.set_en) begin
        used_map[upd.set_slot] <= 1'b1;
      end
      if (upd.clr_en) begin
        used_map[upd.clr_slot] <= 1'b0;
      end
      free_slot <= lowest;
    end
  end

  // A slot is only allocated while it is free, and only released while taken.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    upd.set_en |-> !used_map[upd.set_slot])
    else $error("allocated slot already in use");
  a_release_used: assert property (@(posedge clk) disable iff (rst)
    upd.clr_en |-> used_map[upd.clr_slot])
    else $error("released slot not in use");

endmodule

`default_nettype wire

### rtl/positional_list_engine_core.sv
// Top level of the positional list engine: command decode, list walk and result register.
// Depends on ple_pkg, ple_node_store and ple_free_map.
//
// Usage:
//   Commands arrive on the s_ stream, one item each, and are taken while the
//   engine is idle. Each command answers with one result item on the m_ stream;
//   a dump of a non-empty list answers with one item per entry, head first,
//   with m_tlast set on the final one. Every other command also sets m_tlast.
//   Flow: an insert at the front of the list and every rejected command go straight
//   to the response state after the accept. Commands that walk the list step one
//   link per cycle through the node memory read port (the read address of the next
//   step is the link just read): a positional insert walks to the node before its
//   place, writes the new node and then links it in, a delete walks to its position,
//   a value delete to the first match or the tail, and a dump emits one item per
//   cycle while the receiver is not stalled. The next command can be accepted in the
//   cycle after the last result is loaded. A stalled receiver holds the result
//   register; a dump then pauses on the current entry until the item is taken.
//   Reset clears the list to empty, the free map to all free and drops any
//   pending result.
`default_nettype none

module positional_list_engine_core
  import ple_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // s_tdata: cmd[2:0], item_value[34:3], position[50:35], zero pad[55:51]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // m_tdata: read_value[31:0], length[36:32], zero pad[39:37]
  output logic      [OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: status[2:0]
  output logic      [STAT_W-1:0]      m_tuser,
  output logic                        m_tlast
);

  // Sequencer states and walk modes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  localparam logic [1:0] M_INS  = 2'd0;
  localparam logic [1:0] M_DELP = 2'd1;
  localparam logic [1:0] M_DELV = 2'd2;
  localparam logic [1:0] M_DUMP = 2'd3;

  logic [1:0]        state;
  logic [1:0]        mode;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  prev;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  tgt;
  logic [SLOT_W-1:0] new_slot;
  logic [VAL_W-1:0]  val_reg;
  logic [STAT_W-1:0] stat;

  logic [VAL_W-1:0]  out_value;
  logic [LEN_W-1:0]  out_length;

  logic [SLOT_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_value;
  logic [IDX_W-1:0]  rd_link;
  node_wr_t          node_wr;
  map_upd_t          map_upd;
  logic [SLOT_W-1:0] free_slot;
  logic              map_full;

  ple_node_store u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_link  (rd_link),
    .wr       (node_wr)
  );

  ple_free_map u_map (
    .clk       (clk),
    .rst       (rst),
    .upd       (map_upd),
    .free_slot (free_slot),
    .map_full  (map_full)
  );

  // Input fields.
  logic [CMD_W-1:0] in_cmd;
  logic [VAL_W-1:0] in_val;
  logic [POS_W-1:0] in_pos;
  assign in_cmd = s_tdata[CMD_W-1:0];
  assign in_val = s_tdata[CMD_W+VAL_W-1:CMD_W];
  assign in_pos = s_tdata[CMD_W+VAL_W+POS_W-1:CMD_W+VAL_W];

  logic accept;
  logic out_free;
  logic load;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // A result item is loaded from the response state or from each dump step.
  assign load     = out_free &&
                    ((state == S_RESP) || ((state == S_WALK) && (mode == M_DUMP)));

  // Command decode against the current length.
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   cnt_ext;
  logic             is_full;
  logic             do_ins;
  logic [CNT_W-1:0] ins_k;
  logic             head_ins;
  logic             go_walk;
  logic [1:0]       dec_mode;
  logic [CNT_W-1:0] dec_tgt;
  logic [STAT_W-1:0] dec_stat;

  assign pos_ext = {1'b0, in_pos};
  assign cnt_ext = (POS_W+1)'(count);
  assign is_full = (count >= CNT_W'(CAPACITY)) || map_full;

  always_comb begin
    do_ins   = 1'b0;
    ins_k    = '0;
    head_ins = 1'b0;
    go_walk  = 1'b0;
    dec_mode = M_INS;
    dec_tgt  = '0;
    dec_stat = ST_OK;
    case (in_cmd)
      CMD_INS_HEAD: do_ins = 1'b1;
      CMD_INS_TAIL: begin
        do_ins = 1'b1;
        ins_k  = count;
      end
      CMD_INS_POS: begin
        if (in_pos == '0) begin
          dec_stat = ST_BELOW_ONE;
        end else if (pos_ext > cnt_ext + 1'b1) begin
          dec_stat = ST_OUT_BOUNDS;
        end else begin
          do_ins = 1'b1;
          ins_k  = CNT_W'(in_pos - 1'b1);
        end
      end
      CMD_DEL_POS: begin
        if (count == '0) begin
          dec_stat = ST_EMPTY;
        end else if (in_pos == '0) begin
          dec_stat = ST_BELOW_ONE;
        end else if (pos_ext > cnt_ext) begin
          dec_stat = ST_OUT_BOUNDS;
        end else begin
          go_walk  = 1'b1;
          dec_mode = M_DELP;
          dec_tgt  = CNT_W'(in_pos - 1'b1);
        end
      end
      CMD_DEL_VAL: begin
        if (count == '0) begin
          dec_stat = ST_EMPTY;
        end else begin
          go_walk  = 1'b1;
          dec_mode = M_DELV;
        end
      end
      CMD_DUMP: begin
        if (count == '0) begin
          dec_stat = ST_EMPTY;
        end else begin
          go_walk  = 1'b1;
          dec_mode = M_DUMP;
        end
      end
      default: dec_stat = ST_OK;
    endcase
    // Insertion: the full check follows the position checks.
    if (do_ins) begin
      if (is_full) begin
        dec_stat = ST_FULL;
      end else if (ins_k == '0) begin
        head_ins = 1'b1;
      end else begin
        go_walk  = 1'b1;
        dec_mode = M_INS;
        dec_tgt  = ins_k - 1'b1;
      end
    end
  end

  // Walk step: the node at place step is on the read port in every walk cycle.
  logic [IDX_W-1:0] nxt;
  logic             at_tgt;
  logic             is_last;
  logic             match;
  logic             ins_here;
  logic             remove;
  logic             advance;

  assign nxt     = (rd_link < NIL_INDEX) ? rd_link : NIL_INDEX;
  assign at_tgt  = (step == tgt);
  assign is_last = (CNT_W'(step + 1'b1) == count);
  assign match   = (rd_value == val_reg);

  assign ins_here = (state == S_WALK) && (mode == M_INS) && at_tgt;
  assign remove   = (state == S_WALK) &&
                    (((mode == M_DELP) && at_tgt) || ((mode == M_DELV) && match));

  always_comb begin
    advance = 1'b0;
    if (state == S_WALK) begin
      case (mode)
        M_INS:   advance = !at_tgt;
        M_DELP:  advance = !at_tgt;
        M_DELV:  advance = !match && !is_last;
        default: advance = out_free && !is_last;
      endcase
    end
  end

  // Read address: head when idle, the next link while stepping, else hold.
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = head[SLOT_W-1:0];
    end else if (advance) begin
      rd_addr = nxt[SLOT_W-1:0];
    end else begin
      rd_addr = cur[SLOT_W-1:0];
    end
  end

  // Node memory writes and free map updates.
  always_comb begin
    node_wr = '0;
    map_upd = '0;
    if (accept && head_ins) begin
      node_wr.val_we    = 1'b1;
      node_wr.val_addr  = free_slot;
      node_wr.val_data  = in_val;
      node_wr.link_we   = 1'b1;
      node_wr.link_addr = free_slot;
      node_wr.link_data = head;
      map_upd.set_en    = 1'b1;
      map_upd.set_slot  = free_slot;
    end
    if (ins_here) begin
      node_wr.val_we    = 1'b1;
      node_wr.val_addr  = new_slot;
      node_wr.val_data  = val_reg;
      node_wr.link_we   = 1'b1;
      node_wr.link_addr = new_slot;
      node_wr.link_data = nxt;
      map_upd.set_en    = 1'b1;
      map_upd.set_slot  = new_slot;
    end
    if (state == S_LINK) begin
      node_wr.link_we   = 1'b1;
      node_wr.link_addr = cur[SLOT_W-1:0];
      node_wr.link_data = IDX_W'(new_slot);
    end
    if (remove) begin
      if (step != '0) begin
        node_wr.link_we   = 1'b1;
        node_wr.link_addr = prev[SLOT_W-1:0];
        node_wr.link_data = nxt;
      end
      map_upd.clr_en   = 1'b1;
      map_upd.clr_slot = cur[SLOT_W-1:0];
    end
  end

  // Sequencer, list registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= NIL_INDEX;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val_reg  <= in_val;
            new_slot <= free_slot;
            cur      <= head;
            prev     <= head;
            step     <= '0;
            mode     <= dec_mode;
            tgt      <= dec_tgt;
            stat     <= dec_stat;
            if (head_ins) begin
              head  <= IDX_W'(free_slot);
              count <= count + 1'b1;
            end
            state <= go_walk ? S_WALK : S_RESP;
          end
        end
        S_WALK: begin
          if (advance) begin
            prev <= cur;
            cur  <= nxt;
            step <= step + 1'b1;
          end
          if (ins_here) begin
            count <= count + 1'b1;
            state <= S_LINK;
          end
          if (remove) begin
            if (step == '0) begin
              head <= nxt;
            end
            count <= count - 1'b1;
            stat  <= ST_OK;
            state <= S_RESP;
          end
          if ((mode == M_DELV) && !match && is_last) begin
            stat  <= ST_NOT_FOUND;
            state <= S_RESP;
          end
          if ((mode == M_DUMP) && out_free) begin
            m_tuser    <= ST_OK;
            out_value  <= rd_value;
            out_length <= LEN_W'(count);
            m_tlast    <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_LINK: begin
          stat  <= ST_OK;
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            m_tuser    <= stat;
            out_value  <= '0;
            out_length <= LEN_W'(count);
            m_tlast    <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {(OUT_TDATA_W - VAL_W - LEN_W)'(0), out_length, out_value};

  // List bookkeeping stays consistent.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (head == NIL_INDEX))
    else $error("head index disagrees with entry count");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (step < count) && (cur != NIL_INDEX))
    else $error("walk ran past the end of the list");
  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |=> (state == S_RESP))
    else $error("link write not followed by a result");

endmodule

`default_nettype wire

### tb/ple_tb_pkg.sv
// Shadow copy of the positional list for the testbench: predicts the result items
// of each accepted command and checks the result items that the block returns.
// Depends on ple_pkg for widths, command codes and status codes.

package ple_tb_pkg;
  import ple_pkg::*;

  // One result item as it should appear on the result stream.
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
    logic              last;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  class list_mirror;
    // Values of the list, head first.
    logic [VAL_W-1:0] shadow_values[$];
    // Result items still owed by the block, oldest first.
    list_result_t     awaited_items[$];
    int               errors;
    int               cmd_count[8];
    int               status_count[8];
    int               results_seen;
    int               peak_length;

    // Queue one expected result; the length is the list size after the command.
    function void owe(logic [STAT_W-1:0] st, logic [VAL_W-1:0] v, logic lst);
      list_result_t r;
      r.status = st;
      r.value  = v;
      r.last   = lst;
      r.length = LEN_W'(shadow_values.size());
      awaited_items.push_back(r);
    endfunction

    // Apply one accepted command to the shadow list and queue its results.
    function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      int unsigned len;
      logic [STAT_W-1:0] st;
      int hit;
      len = shadow_values.size();
      st  = ST_OK;
      hit = -1;
      cmd_count[cmd]++;
      case (cmd)
        CMD_INS_HEAD: begin
          if (len >= CAPACITY) st = ST_FULL;
          else shadow_values.push_front(val);
        end
        CMD_INS_TAIL: begin
          if (len >= CAPACITY) st = ST_FULL;
          else shadow_values.push_back(val);
        end
        CMD_INS_POS: begin
          // Range check comes before the full check.
          if (pos < 1) st = ST_BELOW_ONE;
          else if (pos > len + 1) st = ST_OUT_BOUNDS;
          else if (len >= CAPACITY) st = ST_FULL;
          else shadow_values.insert(pos - 1, val);
        end
        CMD_DEL_POS: begin
          // An empty list is reported before any position check.
          if (len == 0) st = ST_EMPTY;
          else if (pos < 1) st = ST_BELOW_ONE;
          else if (pos > len) st = ST_OUT_BOUNDS;
          else shadow_values.delete(pos - 1);
        end
        CMD_DEL_VAL: begin
          if (len == 0) begin
            st = ST_EMPTY;
          end else begin
            for (int k = 0; k < len && hit < 0; k++)
              if (shadow_values[k] == val) hit = k;
            if (hit < 0) st = ST_NOT_FOUND;
            else shadow_values.delete(hit);
          end
        end
        CMD_DUMP: begin
          if (len == 0) begin
            st = ST_EMPTY;
          end else begin
            // One item per entry, head first, last flag on the tail entry.
            for (int k = 0; k < len; k++)
              owe(ST_OK, shadow_values[k], k == len - 1);
            return;
          end
        end
        default: ;
      endcase
      owe(st, '0, 1'b1);
      if (shadow_values.size() > peak_length) peak_length = shadow_values.size();
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one accepted result item with the oldest expectation.
    task check_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] v, logic lst,
                      logic [LEN_W-1:0] len, logic [2:0] pad);
      list_result_t e;
      results_seen++;
      if (awaited_items.size() == 0) begin
        report($sformatf("unexpected result status=%0d value=%0d last=%0b length=%0d",
                         st, $signed(v), lst, len));
        return;
      end
      e = awaited_items.pop_front();
      status_count[e.status]++;
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
      if (v !== e.value)
        report($sformatf("read_value %0d, expected %0d", $signed(v), $signed(e.value)));
      if (lst !== e.last)
        report($sformatf("last %0b, expected %0b", lst, e.last));
      if (len !== e.length)
        report($sformatf("length %0d, expected %0d", len, e.length));
      if (pad !== 3'b000)
        report($sformatf("padding bits of the result are %b", pad));
    endtask
  endclass

endpackage

### tb/positional_list_engine_core_tb.sv
// Self-checking testbench for positional_list_engine_core: directed and random list
// commands with random idling on both streams, checked against a shadow list.
// Depends on ple_pkg, ple_tb_pkg and the block's RTL.

module positional_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;
  import ple_tb_pkg::*;

  typedef logic [CMD_W-1:0] cmd_code_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_CMDS = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;
  logic m_tlast;

  // Set while neither side may idle; hold_req asks the receiver for one long stall.
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int cycle_count = 0;

  list_mirror mirror = new();

  positional_list_engine_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Offer one command item and wait until it is accepted.
  task send_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                input logic [POS_W-1:0] pos);
    if (!steady && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, pos, val, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.note_command(cmd, val, pos);
  endtask

  // Values drawn mostly from a small set so that value deletes find matches.
  function logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return VAL_W'($signed($urandom_range(0, 7)) - 4);
    if (r < 50) return 32'h8000_0000;
    if (r < 55) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  // Position for a positional command: mostly within range, sometimes anything.
  function logic [POS_W-1:0] pick_position(input int unsigned upper);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return POS_W'($urandom());
    if (r < 22) return POS_W'(upper + $urandom_range(1, 2));
    if (upper == 0) return POS_W'(1);
    return POS_W'($urandom_range(1, upper));
  endfunction

  // Value to delete: usually one held in the list.
  function logic [VAL_W-1:0] pick_victim();
    int unsigned len;
    len = mirror.shadow_values.size();
    if (len > 0 && $urandom_range(99) < 70)
      return mirror.shadow_values[$urandom_range(0, len - 1)];
    return pick_value();
  endfunction

  // Result stream receiver, with one long stall on request.
  initial begin
    int hold_count;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      mirror.check_result(m_tuser, m_tdata[31:0], m_tlast, m_tdata[36:32],
                          m_tdata[39:37]);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned len;
    int unsigned r;
    bit grow;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty-list errors, range errors, extremes and a full list.
    send_cmd(CMD_DUMP, '0, '0);
    send_cmd(CMD_DEL_POS, '0, '0);
    send_cmd(CMD_DEL_VAL, 32'h0000_0001, '0);
    send_cmd(CMD_INS_POS, 32'h0000_0011, '0);
    send_cmd(CMD_INS_POS, 32'h0000_0022, 16'd2);
    send_cmd(CMD_INS_POS, 32'h7fff_ffff, 16'd1);
    send_cmd(CMD_INS_HEAD, 32'h8000_0000, '0);
    send_cmd(CMD_INS_TAIL, 32'h0000_0000, '0);
    send_cmd(CMD_INS_POS, 32'hffff_ffff, 16'd4);
    send_cmd(CMD_INS_POS, 32'h0000_0005, 16'd2);
    send_cmd(CMD_INS_TAIL, 32'h0000_0005, '0);
    send_cmd(CMD_DEL_VAL, 32'h0000_0005, '0);
    send_cmd(CMD_DEL_VAL, 32'h0000_3039, '0);
    send_cmd(CMD_DEL_POS, '0, '0);
    send_cmd(CMD_DEL_POS, '0, POS_W'(mirror.shadow_values.size() + 1));
    send_cmd(CMD_DEL_POS, '0, 16'hffff);
    send_cmd(CMD_INS_POS, 32'h0000_0033, 16'hffff);
    send_cmd(3'd6, 32'hffff_ffff, 16'hffff);
    send_cmd(3'd7, 32'h5a5a_a5a5, 16'h5555);
    send_cmd(CMD_DUMP, '0, '0);
    while (mirror.shadow_values.size() < CAPACITY) send_cmd(CMD_INS_TAIL, $urandom(), '0);
    send_cmd(CMD_INS_HEAD, 32'h0000_0044, '0);
    send_cmd(CMD_INS_TAIL, 32'h0000_0055, '0);
    send_cmd(CMD_INS_POS, 32'h0000_0066, 16'd1);
    send_cmd(CMD_INS_POS, 32'h0000_0077, POS_W'(CAPACITY + 2));
    send_cmd(CMD_DUMP, '0, '0);
    send_cmd(CMD_DEL_POS, '0, POS_W'(CAPACITY));
    send_cmd(CMD_DEL_POS, '0, 16'd1);

    // Random part: alternating growing and shrinking stretches.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      steady = (n >= 200 && n < 280);
      if (n == 100) hold_req = 1'b1;
      grow = ((n / 40) % 2) == 0;
      len = mirror.shadow_values.size();
      r = $urandom_range(99);
      if (!grow) r = (r < 16) ? r / 2 : (r < 26 ? r - 1 : r);
      if (r < 20) send_cmd(CMD_INS_HEAD, pick_value(), POS_W'($urandom()));
      else if (r < 40) send_cmd(CMD_INS_TAIL, pick_value(), POS_W'($urandom()));
      else if (r < 60 && grow) send_cmd(CMD_INS_POS, pick_value(), pick_position(len + 1));
      else if (r < 75) send_cmd(CMD_DEL_POS, pick_value(), pick_position(len));
      else if (r < 85) send_cmd(CMD_DEL_VAL, pick_victim(), POS_W'($urandom()));
      else if (r < 95) send_cmd(CMD_DUMP, pick_value(), POS_W'($urandom()));
      else if (r < 97) send_cmd(CMD_INS_POS, pick_value(), pick_position(len + 1));
      else send_cmd(cmd_code_t'(3'd6 + $urandom_range(0, 1)), pick_value(),
                    POS_W'($urandom()));
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain the owed results, then watch for stray items.
    while (mirror.awaited_items.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Ran %0d insert, %0d delete, %0d dump and %0d unused commands; %0d results",
             mirror.cmd_count[0] + mirror.cmd_count[1] + mirror.cmd_count[2],
             mirror.cmd_count[3] + mirror.cmd_count[4], mirror.cmd_count[5],
             mirror.cmd_count[6] + mirror.cmd_count[7], mirror.results_seen);
    $display("Peak list length %0d; full %0d, not found %0d, out of bounds %0d times",
             mirror.peak_length, mirror.status_count[ST_FULL],
             mirror.status_count[ST_NOT_FOUND], mirror.status_count[ST_OUT_BOUNDS]);
    if (mirror.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
